[design/ambmg_pkg.sv]
package ambmg_pkg;

    localparam int LOG_SLOTS   = 16;
    localparam int MIN_SPAN    = 6;
    localparam int HALF_SPAN   = MIN_SPAN / 2;
    localparam int SPAN_CLAMP  = 99;
    localparam int RECIP_TEN   = 205;
    localparam int RECIP_SHIFT = 11;

    localparam int VAL_W   = 10;
    localparam int X_W     = 8;
    localparam int Y_W     = 8;
    localparam int H_W     = 7;
    localparam int KIND_W  = 2;
    localparam int COLX_W  = 9;
    localparam int ROW_W   = 9;
    localparam int DIGIT_W = 4;
    localparam int CLAMP_W = 7;
    localparam int BOT_W   = VAL_W + 2;
    localparam int DIFF_W  = VAL_W + 1;

    localparam int IDX_W = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
    localparam int CNT_W = $clog2(LOG_SLOTS + 1);

    localparam int DIV_NUM_W = H_W + DIFF_W;
    localparam int DIV_DEN_W = VAL_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_ORIGIN_X       = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y       = 2'd1;
    localparam logic [1:0] REG_DIAGRAM_HEIGHT = 2'd2;

    localparam logic [X_W-1:0] ORIGIN_X_RESET = 8'd56;
    localparam logic [Y_W-1:0] ORIGIN_Y_RESET = 8'd0;
    localparam logic [H_W-1:0] HEIGHT_RESET   = 7'd6;

    localparam logic [KIND_W-1:0] KIND_COLUMN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIGITS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] high;
        logic             empty;
        logic             last;
        logic             store;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] high;
        logic             empty;
    } t_slot;

    typedef struct packed {
        logic [X_W-1:0] origin_x;
        logic [Y_W-1:0] origin_y;
        logic [H_W-1:0] diagram_height;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [COLX_W-1:0]  column_x;
        logic [ROW_W-1:0]   row_top;
        logic [ROW_W-1:0]   row_bottom;
        logic               column_drawn;
        logic [DIGIT_W-1:0] span_tens;
        logic               tens_shown;
        logic [DIGIT_W-1:0] span_ones;
        logic               last_result;
    } t_result;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SETUP,
        BK_READ,
        BK_COL_LO,
        BK_WAIT_LO,
        BK_COL_HI,
        BK_WAIT_HI,
        BK_EMIT,
        BK_DIGITS,
        BK_NONE
    } t_back_state;

endpackage

[design/ambmg_if.sv]
interface ambmg_in_if import ambmg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] slot_low;
    logic [VAL_W-1:0] slot_high;
    logic             slot_empty;
    logic             last_slot;

    modport source (output valid, slot_low, slot_high, slot_empty, last_slot, input ready);
    modport sink   (input valid, slot_low, slot_high, slot_empty, last_slot, output ready);
endinterface

interface ambmg_out_if import ambmg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  result_kind;
    logic [COLX_W-1:0]  column_x;
    logic [ROW_W-1:0]   row_top;
    logic [ROW_W-1:0]   row_bottom;
    logic               column_drawn;
    logic [DIGIT_W-1:0] span_tens;
    logic               tens_shown;
    logic [DIGIT_W-1:0] span_ones;
    logic               last_result;

    modport source (output valid, result_kind, column_x, row_top, row_bottom, column_drawn,
                    span_tens, tens_shown, span_ones, last_result, input ready);
    modport sink   (input valid, result_kind, column_x, row_top, row_bottom, column_drawn,
                    span_tens, tens_shown, span_ones, last_result, output ready);
endinterface

[design/ambmg_front.sv]
module ambmg_front import ambmg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ambmg_in_if.sink   i_in,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_push_ready
);

    logic [CNT_W-1:0] r_cnt;
    logic             w_swap;
    logic             w_store;

    assign i_in.ready = i_push_ready;
    assign o_push     = i_in.valid;

    assign w_swap  = i_in.slot_low > i_in.slot_high;
    assign w_store = r_cnt < CNT_W'(LOG_SLOTS);

    always_comb begin
        o_cmd.low   = w_swap ? i_in.slot_high : i_in.slot_low;
        o_cmd.high  = w_swap ? i_in.slot_low : i_in.slot_high;
        o_cmd.empty = i_in.slot_empty;
        o_cmd.last  = i_in.last_slot;
        o_cmd.store = w_store;
        o_cmd.idx   = r_cnt[IDX_W-1:0];
        o_cmd.count = w_store ? r_cnt + CNT_W'(1) : r_cnt;
    end

    // slot counter restarts after the word that ends the log
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_in.valid && i_push_ready) begin
            r_cnt <= i_in.last_slot ? '0 : o_cmd.count;
        end
    end

endmodule

[design/ambmg_fifo.sv]
module ambmg_fifo import ambmg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_fill;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_push_ready = r_fill != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_cmd        = r_mem[r_rptr];
    assign w_do_push    = i_push && o_push_ready;
    assign w_do_pop     = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_fill <= r_fill + QCNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_fill <= r_fill - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

[design/ambmg_div.sv]
module ambmg_div import ambmg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    // restoring division, one quotient bit a cycle
    assign w_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
        end
    end

endmodule

[design/ambmg_back.sv]
module ambmg_back import ambmg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_ready,
    ambmg_out_if.source o_out
);

    t_back_state              r_state;
    t_back_state              n_state;

    t_slot                    r_mem [LOG_SLOTS];
    t_slot                    r_rd;

    logic [VAL_W-1:0]         r_low;
    logic [VAL_W-1:0]         r_high;
    logic                     r_any;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;

    logic signed [BOT_W-1:0]  r_bottom;
    logic [DIV_DEN_W-1:0]     r_den;
    logic [H_W-1:0]           r_hm1;
    logic [ROW_W-1:0]         r_base;
    logic [CLAMP_W-1:0]       r_span_c;
    logic [H_W-1:0]           r_jl;
    logic [H_W-1:0]           r_jh;

    logic                     r_out_valid;
    t_result                  r_out;

    logic                     w_pop;
    logic                     w_take;
    logic                     w_setup;
    logic                     w_div_start;
    logic                     w_div_sel_hi;
    logic                     w_lat_lo;
    logic                     w_lat_hi;
    logic                     w_load_col;
    logic                     w_load_dig;
    logic                     w_load_none;
    logic                     w_out_free;
    logic                     w_last_col;

    logic [VAL_W-1:0]         w_span;
    logic [VAL_W-1:0]         w_mid;
    logic                     w_wide;
    logic [H_W-1:0]           w_hm1;
    logic [VAL_W-1:0]         w_level_v;
    logic signed [BOT_W-1:0]  w_diff;
    logic [DIFF_W-1:0]        w_dpos;
    logic [DIV_NUM_W-1:0]     w_num;
    logic                     w_div_done;
    logic [DIV_NUM_W-1:0]     w_quot;
    logic [H_W-1:0]           w_lvl;
    logic [2*CLAMP_W:0]       w_tens_prod;
    logic [DIGIT_W-1:0]       w_tens;
    logic [DIGIT_W-1:0]       w_ones;
    logic                     w_shown;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_take     = w_pop && i_q_valid;
    assign w_last_col = (r_idx + CNT_W'(1)) == r_count;
    assign o_q_ready  = w_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && i_q_cmd.last) n_state = BK_SETUP;
            end
            BK_SETUP: begin
                n_state = r_any ? BK_READ : BK_NONE;
            end
            BK_READ: begin
                n_state = BK_COL_LO;
            end
            BK_COL_LO: begin
                n_state = r_rd.empty ? BK_EMIT : BK_WAIT_LO;
            end
            BK_WAIT_LO: begin
                if (w_div_done) n_state = BK_COL_HI;
            end
            BK_COL_HI: begin
                n_state = BK_WAIT_HI;
            end
            BK_WAIT_HI: begin
                if (w_div_done) n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (w_out_free) n_state = w_last_col ? BK_DIGITS : BK_READ;
            end
            BK_DIGITS: begin
                if (w_out_free) n_state = BK_IDLE;
            end
            BK_NONE: begin
                if (w_out_free) n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        w_pop        = 1'b0;
        w_setup      = 1'b0;
        w_div_start  = 1'b0;
        w_div_sel_hi = 1'b0;
        w_lat_lo     = 1'b0;
        w_lat_hi     = 1'b0;
        w_load_col   = 1'b0;
        w_load_dig   = 1'b0;
        w_load_none  = 1'b0;
        case (r_state)
            BK_IDLE:    w_pop = 1'b1;
            BK_SETUP:   w_setup = 1'b1;
            BK_COL_LO:  w_div_start = !r_rd.empty;
            BK_WAIT_LO: w_lat_lo = w_div_done;
            BK_COL_HI: begin
                w_div_start  = 1'b1;
                w_div_sel_hi = 1'b1;
            end
            BK_WAIT_HI: w_lat_hi = w_div_done;
            BK_EMIT:    w_load_col = w_out_free;
            BK_DIGITS:  w_load_dig = w_out_free;
            BK_NONE:    w_load_none = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot store
    always_ff @(posedge i_clk) begin
        if (w_take && i_q_cmd.store) begin
            r_mem[i_q_cmd.idx] <= '{low: i_q_cmd.low, high: i_q_cmd.high,
                                    empty: i_q_cmd.empty};
        end
        r_rd <= r_mem[r_idx[IDX_W-1:0]];
    end

    // running extremes over slots with data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '1;
            r_high <= '0;
            r_any  <= 1'b0;
        end else if (w_load_dig || w_load_none) begin
            r_low  <= '1;
            r_high <= '0;
            r_any  <= 1'b0;
        end else if (w_take && i_q_cmd.store && !i_q_cmd.empty) begin
            if (i_q_cmd.high > r_high) r_high <= i_q_cmd.high;
            if (i_q_cmd.low < r_low) r_low <= i_q_cmd.low;
            r_any <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (w_take && i_q_cmd.last) r_count <= i_q_cmd.count;
            if (w_setup) begin
                r_idx <= '0;
            end else if (w_load_col) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // vertical scale
    assign w_span = r_high - r_low;
    assign w_mid  = VAL_W'(({1'b0, r_high} + {1'b0, r_low}) >> 1);
    assign w_wide = w_span > VAL_W'(MIN_SPAN);
    assign w_hm1  = (i_cfg.diagram_height == '0) ? '0 : i_cfg.diagram_height - H_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_setup) begin
            if (w_wide) begin
                r_bottom <= $signed({2'b00, r_low});
                r_den    <= w_span;
            end else begin
                r_bottom <= $signed({2'b00, w_mid}) - $signed(BOT_W'(HALF_SPAN));
                r_den    <= DIV_DEN_W'(2 * HALF_SPAN);
            end
            r_hm1    <= w_hm1;
            r_base   <= ROW_W'(i_cfg.origin_y) + ROW_W'(w_hm1);
            r_span_c <= (w_span > VAL_W'(SPAN_CLAMP)) ? CLAMP_W'(SPAN_CLAMP)
                                                      : w_span[CLAMP_W-1:0];
        end
    end

    // level of one reading: hm1 * (v - bottom) / den, clamped to [0, hm1]
    assign w_level_v = w_div_sel_hi ? r_rd.high : r_rd.low;
    assign w_diff    = $signed({2'b00, w_level_v}) - r_bottom;
    assign w_dpos    = w_diff[BOT_W-1] ? '0 : w_diff[DIFF_W-1:0];
    assign w_num     = DIV_NUM_W'(r_hm1) * DIV_NUM_W'(w_dpos);
    assign w_lvl     = (w_quot > DIV_NUM_W'(r_hm1)) ? r_hm1 : w_quot[H_W-1:0];

    ambmg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_lat_lo) r_jl <= w_lvl;
        if (w_lat_hi) r_jh <= w_lvl;
    end

    // span digits, tens by reciprocal multiply
    assign w_tens_prod = (2*CLAMP_W+1)'(r_span_c) * (2*CLAMP_W+1)'(RECIP_TEN);
    assign w_tens      = DIGIT_W'(w_tens_prod >> RECIP_SHIFT);
    assign w_ones      = DIGIT_W'(r_span_c - CLAMP_W'(w_tens) * CLAMP_W'(10));
    assign w_shown     = r_span_c > CLAMP_W'(9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_col || w_load_dig || w_load_none) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_col) begin
            r_out              <= '0;
            r_out.result_kind  <= KIND_COLUMN;
            r_out.column_x     <= COLX_W'(i_cfg.origin_x) + COLX_W'(r_idx);
            r_out.column_drawn <= !r_rd.empty;
            r_out.row_top      <= r_rd.empty ? '0 : r_base - ROW_W'(r_jh);
            r_out.row_bottom   <= r_rd.empty ? '0 : r_base - ROW_W'(r_jl);
        end else if (w_load_dig) begin
            r_out             <= '0;
            r_out.result_kind <= KIND_DIGITS;
            r_out.span_tens   <= w_shown ? w_tens : '0;
            r_out.tens_shown  <= w_shown;
            r_out.span_ones   <= w_ones;
            r_out.last_result <= 1'b1;
        end else if (w_load_none) begin
            r_out             <= '0;
            r_out.result_kind <= KIND_NONE;
            r_out.last_result <= 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_out.result_kind;
    assign o_out.column_x     = r_out.column_x;
    assign o_out.row_top      = r_out.row_top;
    assign o_out.row_bottom   = r_out.row_bottom;
    assign o_out.column_drawn = r_out.column_drawn;
    assign o_out.span_tens    = r_out.span_tens;
    assign o_out.tens_shown   = r_out.tens_shown;
    assign o_out.span_ones    = r_out.span_ones;
    assign o_out.last_result  = r_out.last_result;

endmodule

[design/autoscaled_minmax_bar_graph.sv]
// Min/max bar graph with automatic vertical scale.
// i_in takes one log slot per word (low, high, empty mark, last mark); a
// two-word queue sits between the loader and the renderer, so slots are
// taken one per cycle while the queue has room.
// The word with last_slot set starts rendering: one column word on o_out
// per loaded slot, then one word with the span digits and last_result set,
// or a single no-data word with last_result set when no slot had data.
// Rendering once the last slot leaves the queue: a setup step, then per
// drawn column two 18-step serial divisions for the bottom and top levels,
// per empty column no division, and last the digit word.
// The APB port (psel/penable/pwrite/paddr/pwdata, pready tied high) holds
// origin_x at 0x0, origin_y at 0x4 and diagram_height at 0x8; write them
// only while no log is being loaded or rendered.
// Reset sets the registers to 56, 0 and 6 and clears the running extremes
// and slot counter; the slot store holds no defined data until loaded.
// When o_out is stalled the result stays in the output register, the
// renderer waits, and once the queue is full i_in.ready drops.
module autoscaled_minmax_bar_graph import ambmg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ambmg_in_if.sink          i_in,
    ambmg_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [X_W-1:0] r_origin_x;
    logic [Y_W-1:0] r_origin_y;
    logic [H_W-1:0] r_height;
    logic [1:0]     w_reg_idx;
    logic           w_wr;
    t_cfg           w_cfg;

    logic           w_push;
    logic           w_push_ready;
    t_cmd           w_push_cmd;
    logic           w_q_valid;
    logic           w_q_ready;
    t_cmd           w_q_cmd;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ORIGIN_X_RESET;
            r_origin_y <= ORIGIN_Y_RESET;
            r_height   <= HEIGHT_RESET;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_ORIGIN_X:       r_origin_x <= pwdata[X_W-1:0];
                REG_ORIGIN_Y:       r_origin_y <= pwdata[Y_W-1:0];
                REG_DIAGRAM_HEIGHT: r_height   <= pwdata[H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_ORIGIN_X:       prdata = APB_DW'(r_origin_x);
            REG_ORIGIN_Y:       prdata = APB_DW'(r_origin_y);
            REG_DIAGRAM_HEIGHT: prdata = APB_DW'(r_height);
            default:            prdata = '0;
        endcase
    end

    assign w_cfg = '{origin_x: r_origin_x, origin_y: r_origin_y, diagram_height: r_height};

    ambmg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd),
        .i_push_ready (w_push_ready)
    );

    ambmg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_q_valid),
        .o_cmd        (w_q_cmd),
        .i_pop        (w_q_ready)
    );

    ambmg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_ready (w_q_ready),
        .o_out     (o_out)
    );

    // an accepted word that is not popped leaves the queue non-empty
    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !(w_q_valid && w_q_ready)) |=> w_q_valid)
        else $error("queue lost an accepted word");

    // only the digit or no-data word closes a run
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_result == (o_out.result_kind != KIND_COLUMN)))
        else $error("last_result does not match result kind");

    // a stalled result word holds its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.result_kind)
            && $stable(o_out.column_x) && $stable(o_out.row_top)
            && $stable(o_out.row_bottom) && $stable(o_out.span_ones)))
        else $error("stalled result word changed");

endmodule
